[src/dted_pkg.sv]
`timescale 1ns / 1ps

package dted_pkg;

  // Sample and threshold format
  localparam int SAMPLE_W = 16;

  // Debounce length limits and counter widths
  localparam int MAX_DEBOUNCE = 256;
  localparam int RUN_W        = $clog2(MAX_DEBOUNCE + 1);
  localparam int COUNT_W      = 32;
  localparam int CELL_W       = 8;
  localparam int CELL_COUNT   = COUNT_W / CELL_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MASK_W     = 2;

  // Output packing: rise, fall, index, stable, rising total, falling total
  localparam int OUT_BITS   = 3 + 3 * COUNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Counter lanes inside each cell
  localparam int LANE_COUNT = 3;
  localparam int LANE_INDEX = 0;
  localparam int LANE_RISE  = 1;
  localparam int LANE_FALL  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_DEBOUNCE   = 2'd1,
    REG_EDGE_MASK  = 2'd2
  } reg_index_t;

  // Link between the front stage and the counter cells, and between cells
  typedef struct packed {
    logic                                 valid;
    logic [LANE_COUNT-1:0]                carry;
    logic [LANE_COUNT-1:0][COUNT_W-1:0]   word;
    logic                                 rise;
    logic                                 fall;
    logic                                 stable;
  } link_t;

endpackage

[src/dted_front.sv]
`timescale 1ns / 1ps

module dted_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dted_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dted_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  input  logic signed [dted_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  advance,
  output dted_pkg::link_t                       link_out
);

  logic signed [dted_pkg::SAMPLE_W-1:0] threshold;
  logic [dted_pkg::RUN_W-1:0]           debounce_count;
  logic [dted_pkg::MASK_W-1:0]          edge_mask;

  logic                                 run_level;
  logic [dted_pkg::RUN_W-1:0]           run_length;
  logic                                 settled_level;

  logic                                 run_level_next;
  logic [dted_pkg::RUN_W-1:0]           run_length_next;
  logic                                 settled_level_next;
  logic [dted_pkg::RUN_W-1:0]           eff_len;
  logic                                 level;
  logic                                 rise_edge;
  logic                                 fall_edge;
  logic                                 accept;
  dted_pkg::link_t                      link_next;

  assign accept = in_valid && advance;

  // Clamp the debounce length into 1..MAX_DEBOUNCE
  always_comb begin
    if (debounce_count == '0) begin
      eff_len = dted_pkg::RUN_W'(1);
    end else if (debounce_count > dted_pkg::RUN_W'(dted_pkg::MAX_DEBOUNCE)) begin
      eff_len = dted_pkg::RUN_W'(dted_pkg::MAX_DEBOUNCE);
    end else begin
      eff_len = debounce_count;
    end
  end

  // Level, run tracking and settled level update for one sample
  always_comb begin
    level              = (sample >= threshold);
    run_level_next     = run_level;
    run_length_next    = run_length;
    settled_level_next = settled_level;
    rise_edge          = 1'b0;
    fall_edge          = 1'b0;
    if (run_length == '0 || level != run_level) begin
      run_level_next  = level;
      run_length_next = dted_pkg::RUN_W'(1);
    end else if (run_length < eff_len) begin
      run_length_next = run_length + dted_pkg::RUN_W'(1);
    end
    if (run_length_next > eff_len) begin
      run_length_next = eff_len;
    end
    if (run_length_next >= eff_len) begin
      if (run_level_next && !settled_level) begin
        settled_level_next = 1'b1;
        rise_edge          = 1'b1;
      end else if (!run_level_next && settled_level) begin
        settled_level_next = 1'b0;
        fall_edge          = 1'b1;
      end
    end
  end

  // Build the request handed to the first counter cell
  always_comb begin
    link_next                              = '0;
    link_next.valid                        = accept;
    link_next.carry[dted_pkg::LANE_INDEX]  = accept;
    link_next.carry[dted_pkg::LANE_RISE]   = accept && rise_edge;
    link_next.carry[dted_pkg::LANE_FALL]   = accept && fall_edge;
    link_next.rise                         = rise_edge && edge_mask[0];
    link_next.fall                         = fall_edge && edge_mask[1];
    link_next.stable                       = settled_level_next;
  end

  // Configuration registers and debounce state
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= '0;
      debounce_count <= dted_pkg::RUN_W'(1);
      edge_mask      <= '1;
      run_level      <= 1'b0;
      run_length     <= '0;
      settled_level  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dted_pkg::REG_THRESHOLD: begin
            threshold <= cfg_data[dted_pkg::SAMPLE_W-1:0];
          end
          dted_pkg::REG_DEBOUNCE: begin
            debounce_count <= cfg_data[dted_pkg::RUN_W-1:0];
          end
          dted_pkg::REG_EDGE_MASK: begin
            edge_mask <= cfg_data[dted_pkg::MASK_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cfg_we && cfg_index == dted_pkg::REG_DEBOUNCE) begin
        run_length <= '0;
      end else if (accept) begin
        run_length <= run_length_next;
      end
      if (accept) begin
        run_level     <= run_level_next;
        settled_level <= settled_level_next;
      end
    end
  end

  // Output register toward the cell chain
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else if (advance) begin
      link_out <= link_next;
    end
  end

endmodule

[src/dted_cell.sv]
`timescale 1ns / 1ps

module dted_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  dted_pkg::link_t link_in,
  output dted_pkg::link_t link_out
);

  logic [dted_pkg::LANE_COUNT-1:0][dted_pkg::CELL_W-1:0] slice;
  logic [dted_pkg::LANE_COUNT-1:0][dted_pkg::CELL_W-1:0] slice_next;
  dted_pkg::link_t                                       link_next;

  // Add the incoming carry to this cell's byte of each counter and
  // shift the byte into the top of the word that travels on
  always_comb begin
    link_next        = link_in;
    link_next.valid  = link_in.valid;
    for (int i = 0; i < dted_pkg::LANE_COUNT; i++) begin
      slice_next[i] = slice[i] + dted_pkg::CELL_W'(link_in.carry[i]);
      link_next.carry[i] = link_in.carry[i] && (slice[i] == '1);
      link_next.word[i]  = {slice_next[i],
                            link_in.word[i][dted_pkg::COUNT_W-1:dted_pkg::CELL_W]};
    end
  end

  // Hold the counter bytes; the index lane starts at all ones so that the
  // first sample reads index zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dted_pkg::LANE_COUNT; i++) begin
        slice[i] <= (i == dted_pkg::LANE_INDEX) ? '1 : '0;
      end
      link_out <= '0;
    end else if (advance) begin
      slice    <= slice_next;
      link_out <= link_next;
    end
  end

endmodule

[src/debounced_threshold_edge_detector.sv]
`timescale 1ns / 1ps
// A sample accepted by the front stage is registered there, then passes
// through each of the four counter cells in turn, each registering it, before
// it shows on the master side.
// Throughput: one sample per cycle; the whole chain stalls together while a result waits.
// Reset (rst, synchronous): registers return to threshold 0, debounce 1, mask 3,
// and all runs, levels and edge totals clear; the sample index restarts at zero.

module debounced_threshold_edge_detector (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [dted_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dted_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Sample stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [dted_pkg::SAMPLE_W-1:0]         s_tdata,   // [15:0] sample
  // Result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [0] rising_event, [1] falling_event, [33:2] event_index, [34] stable_level,
  // [66:35] rising_total, [98:67] falling_total, rest zero
  output logic [dted_pkg::OUT_DATA_W-1:0]       m_tdata
);

  dted_pkg::link_t link [dted_pkg::CELL_COUNT+1];
  logic            advance;

  // Advance the whole chain unless the last result is waiting
  assign advance  = !link[dted_pkg::CELL_COUNT].valid || m_tready;
  assign s_tready = advance;

  dted_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .sample    (s_tdata),
    .advance   (advance),
    .link_out  (link[0])
  );

  // Row of counter cells, one byte of every counter each
  for (genvar k = 0; k < dted_pkg::CELL_COUNT; k++) begin : g_cell
    dted_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .link_in  (link[k]),
      .link_out (link[k+1])
    );
  end

  // Pack the result
  assign m_tvalid = link[dted_pkg::CELL_COUNT].valid;
  assign m_tdata  = {
    (dted_pkg::OUT_DATA_W - dted_pkg::OUT_BITS)'(0),
    link[dted_pkg::CELL_COUNT].word[dted_pkg::LANE_FALL],
    link[dted_pkg::CELL_COUNT].word[dted_pkg::LANE_RISE],
    link[dted_pkg::CELL_COUNT].stable,
    link[dted_pkg::CELL_COUNT].word[dted_pkg::LANE_INDEX],
    link[dted_pkg::CELL_COUNT].fall,
    link[dted_pkg::CELL_COUNT].rise
  };

  // A result never flags both edges
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("rising and falling event on the same sample");

  // A rising event leaves the stable level high
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[34])
    else $error("rising event with stable level low");

  // A falling event leaves the stable level low
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> !m_tdata[34])
    else $error("falling event with stable level high");

  // A stalled chain takes no new sample
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("sample taken while result stalled");

endmodule

[bench/dted_result_checker.sv]
`timescale 1ns / 1ps

module dted_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dted_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dted_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [dted_pkg::SAMPLE_W-1:0]   s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [dted_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                              mismatches,
  output int                              pending,
  output int                              checked,
  output int                              rise_flags,
  output int                              fall_flags
);

  typedef struct packed {
    logic                         rising;
    logic                         falling;
    logic [dted_pkg::COUNT_W-1:0] index;
    logic                         stable;
    logic [dted_pkg::COUNT_W-1:0] rise_total;
    logic [dted_pkg::COUNT_W-1:0] fall_total;
  } edge_report_t;

  // Expected reports, oldest first
  edge_report_t awaited_reports[$];

  // Register copies
  logic signed [dted_pkg::SAMPLE_W-1:0] thr;
  logic [dted_pkg::RUN_W-1:0]           deb;
  logic [dted_pkg::MASK_W-1:0]          mask;

  // Detector state
  logic                                 run_lvl;
  logic [dted_pkg::RUN_W-1:0]           run_len;
  logic                                 settled;
  logic [dted_pkg::COUNT_W-1:0]         sample_idx;
  logic [dted_pkg::COUNT_W-1:0]         rise_cnt;
  logic [dted_pkg::COUNT_W-1:0]         fall_cnt;

  // Advance the debounce state by one sample and build its report
  task automatic step_detector(input logic signed [dted_pkg::SAMPLE_W-1:0] smp,
                               output edge_report_t r);
    logic [dted_pkg::RUN_W-1:0] need;
    logic                       lvl;
    need = (deb == '0) ? dted_pkg::RUN_W'(1)
         : (deb > dted_pkg::RUN_W'(dted_pkg::MAX_DEBOUNCE))
           ? dted_pkg::RUN_W'(dted_pkg::MAX_DEBOUNCE) : deb;
    lvl  = (smp >= thr);
    r    = '0;
    // restart the run on a level change, else extend it up to the length
    if (run_len == '0 || lvl != run_lvl) begin
      run_lvl = lvl;
      run_len = dted_pkg::RUN_W'(1);
    end else if (run_len < need) begin
      run_len = run_len + dted_pkg::RUN_W'(1);
    end
    // settle once the run is long enough
    if (run_len >= need) begin
      if (run_lvl && !settled) begin
        settled  = 1'b1;
        rise_cnt = rise_cnt + dted_pkg::COUNT_W'(1);
        r.rising = mask[0];
      end else if (!run_lvl && settled) begin
        settled   = 1'b0;
        fall_cnt  = fall_cnt + dted_pkg::COUNT_W'(1);
        r.falling = mask[1];
      end
    end
    r.index      = sample_idx;
    r.stable     = settled;
    r.rise_total = rise_cnt;
    r.fall_total = fall_cnt;
    sample_idx   = sample_idx + dted_pkg::COUNT_W'(1);
  endtask

  task automatic flag_mismatch(input string what,
                               input logic [dted_pkg::COUNT_W-1:0] idx,
                               input logic [dted_pkg::COUNT_W-1:0] got,
                               input logic [dted_pkg::COUNT_W-1:0] want);
    $display("mismatch on %s at sample %0d: got %0h, expected %0h", what, idx, got, want);
    mismatches++;
  endtask

  // Compare results, track register writes, predict accepted requests
  always @(posedge clk) begin : watch
    edge_report_t want;
    edge_report_t fresh;
    if (rst) begin
      thr        = '0;
      deb        = dted_pkg::RUN_W'(1);
      mask       = 2'b11;
      run_lvl    = 1'b0;
      run_len    = '0;
      settled    = 1'b0;
      sample_idx = '0;
      rise_cnt   = '0;
      fall_cnt   = '0;
      awaited_reports.delete();
      mismatches = 0;
      checked    = 0;
      rise_flags = 0;
      fall_flags = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_reports.size() == 0) begin
          flag_mismatch("result with none expected", m_tdata[33:2], m_tdata[33:2], '0);
        end else begin
          want = awaited_reports[0];
          awaited_reports.delete(0);
          if (m_tdata[0] !== want.rising)
            flag_mismatch("rising_event", want.index,
                          dted_pkg::COUNT_W'(m_tdata[0]),
                          dted_pkg::COUNT_W'(want.rising));
          if (m_tdata[1] !== want.falling)
            flag_mismatch("falling_event", want.index,
                          dted_pkg::COUNT_W'(m_tdata[1]),
                          dted_pkg::COUNT_W'(want.falling));
          if (m_tdata[33:2] !== want.index)
            flag_mismatch("event_index", want.index, m_tdata[33:2], want.index);
          if (m_tdata[34] !== want.stable)
            flag_mismatch("stable_level", want.index,
                          dted_pkg::COUNT_W'(m_tdata[34]),
                          dted_pkg::COUNT_W'(want.stable));
          if (m_tdata[66:35] !== want.rise_total)
            flag_mismatch("rising_total", want.index, m_tdata[66:35], want.rise_total);
          if (m_tdata[98:67] !== want.fall_total)
            flag_mismatch("falling_total", want.index, m_tdata[98:67], want.fall_total);
          checked++;
          rise_flags += int'(want.rising);
          fall_flags += int'(want.falling);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          dted_pkg::REG_THRESHOLD: thr = cfg_data;
          dted_pkg::REG_DEBOUNCE: begin
            deb     = cfg_data[dted_pkg::RUN_W-1:0];
            run_len = '0;
          end
          dted_pkg::REG_EDGE_MASK: mask = cfg_data[dted_pkg::MASK_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        step_detector(s_tdata, fresh);
        awaited_reports = {awaited_reports, fresh};
      end
    end
    pending = awaited_reports.size();
  end

endmodule

[bench/debounced_threshold_edge_detector_tb.sv]
`timescale 1ns / 1ps

module debounced_threshold_edge_detector_tb;

  localparam logic [dted_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind this index
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;

  typedef enum int {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [dted_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dted_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [dted_pkg::SAMPLE_W-1:0]   s_tdata   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [dted_pkg::OUT_DATA_W-1:0] m_tdata;

  int mismatches, pending, checked, rise_flags, fall_flags;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  int reg_writes    = 0;

  // Sample shaping: current threshold, debounce length and run in progress
  int   cur_thr  = 0;
  int   cur_need = 1;
  int   run_left = 0;
  logic lvl_now  = 1'b0;

  debounced_threshold_edge_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  dted_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .rise_flags (rise_flags),
    .fall_flags (fall_flags)
  );

  always #4 clk = ~clk;

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               idle_cycles, pending);
      $display("debounced_threshold_edge_detector_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_gaps(input gap_mode_t mode);
    case (mode)
      GAP_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      GAP_SENDER:   begin send_idle_pct = 79; stall_pct = 0;  end
      GAP_RECEIVER: begin send_idle_pct = 0;  stall_pct = 79; end
      GAP_BOTH:     begin send_idle_pct = 20; stall_pct = 20; end
      default:      begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Write one register, then drop the enable again
  task automatic write_reg(input logic [dted_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dted_pkg::CFG_DATA_W-1:0] val);
    int d;
    d = int'(val[dted_pkg::RUN_W-1:0]);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      dted_pkg::REG_THRESHOLD: cur_thr = int'($signed(val));
      dted_pkg::REG_DEBOUNCE: begin
        cur_need = (d == 0) ? 1 : (d > dted_pkg::MAX_DEBOUNCE) ? dted_pkg::MAX_DEBOUNCE : d;
        run_left = 0;
      end
      default: ;
    endcase
  endtask

  // Offer one sample, idling first at random, and hold it until accepted
  task automatic send_sample(input logic [dted_pkg::SAMPLE_W-1:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and wait until every expected result has arrived
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Pick a sample on the requested side of the threshold, edges favored
  function automatic logic [dted_pkg::SAMPLE_W-1:0] pick_sample(input logic hi);
    int lo_v;
    int hi_v;
    if (hi) begin
      lo_v = cur_thr;
      hi_v = 32767;
    end else begin
      lo_v = -32768;
      hi_v = cur_thr - 1;
    end
    // nothing lies below the lowest threshold
    if (hi_v < lo_v) begin
      lo_v = cur_thr;
      hi_v = 32767;
    end
    case ($urandom_range(3))
      0:       return dted_pkg::SAMPLE_W'(lo_v);
      1:       return dted_pkg::SAMPLE_W'(hi_v);
      default: return dted_pkg::SAMPLE_W'(lo_v + int'($urandom_range(hi_v - lo_v)));
    endcase
  endfunction

  // Runs of one level, mostly long enough to settle, some short glitches, some noise
  function automatic logic [dted_pkg::SAMPLE_W-1:0] next_sample();
    if ($urandom_range(99) < 8) return dted_pkg::SAMPLE_W'($urandom);
    if (run_left == 0) begin
      if ($urandom_range(99) < 80) lvl_now = !lvl_now;
      if ($urandom_range(99) < 70)
        run_left = cur_need + int'($urandom_range(3));
      else
        run_left = 1 + int'($urandom_range((cur_need > 1) ? cur_need - 2 : 0));
    end
    run_left--;
    return pick_sample(lvl_now);
  endfunction

  initial begin
    int n_items;
    int deb;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: the level follows every sample, every edge flagged
    set_gaps(GAP_NONE);
    send_sample(16'h0000);  // sample equal to threshold counts as high
    send_sample(16'hFFFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0000);

    // Lowest threshold, no edges reported, zero length, write to a spare index
    drain_results();
    write_reg(dted_pkg::REG_THRESHOLD, 16'h8000);
    write_reg(dted_pkg::REG_EDGE_MASK, 16'h0000);
    write_reg(dted_pkg::REG_DEBOUNCE, 16'h0000);
    write_reg(REG_SPARE, 16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);

    // Highest threshold, length 3 with upper data bits set, falling only
    drain_results();
    write_reg(dted_pkg::REG_THRESHOLD, 16'h7FFF);
    write_reg(dted_pkg::REG_DEBOUNCE, 16'hFE03);
    write_reg(dted_pkg::REG_EDGE_MASK, 16'h0002);
    send_sample(16'h0000);
    send_sample(16'h0000);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);

    // Length beyond the limit clamps, rising only
    drain_results();
    write_reg(dted_pkg::REG_DEBOUNCE, 16'h01FF);
    write_reg(dted_pkg::REG_EDGE_MASK, 16'h0001);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'hFF9C);

    // Random phases, one register setting and one idling pattern each
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      set_gaps(gap_mode_t'(p % 4));
      write_reg(dted_pkg::REG_THRESHOLD,
                (p == 1) ? 16'h7FFF : (p == 2) ? 16'h8000 : 16'($urandom));
      case (p)
        0, 6:    deb = 1;
        2:       deb = 0;
        4:       deb = dted_pkg::MAX_DEBOUNCE;
        default: deb = $urandom_range(2, 8);
      endcase
      write_reg(dted_pkg::REG_DEBOUNCE, 16'(deb));
      write_reg(dted_pkg::REG_EDGE_MASK, 16'(p % 4));
      n_items = (cur_need > 32) ? 300 : 60;
      for (int k = 0; k < n_items; k++) begin
        // long receiver hold-off while samples keep coming
        if (p == 0 && k == 30) hold_reqs++;
        send_sample(next_sample());
      end
    end

    drain_results();
    $display("%0d samples checked across %0d register writes and four idling patterns",
             checked, reg_writes);
    $display("%0d rising and %0d falling events flagged, debounce lengths 1 to %0d",
             rise_flags, fall_flags, dted_pkg::MAX_DEBOUNCE);
    if (mismatches == 0 && pending == 0)
      $display("debounced_threshold_edge_detector_tb: clean");
    else
      $display("debounced_threshold_edge_detector_tb: errors");
    $finish;
  end

endmodule

[filelist.f]
src/dted_pkg.sv
src/dted_front.sv
src/dted_cell.sv
src/debounced_threshold_edge_detector.sv
bench/dted_result_checker.sv
bench/debounced_threshold_edge_detector_tb.sv
